FILE: hw/rtl/gaussian_bilinear_tap_generator_unit_defines.svh
// Assertion helpers for the RTL of the tap generator.
// The module that uses them provides clk_i and rst_ni.
`ifndef GAUSSIAN_BILINEAR_TAP_GENERATOR_UNIT_DEFINES_SVH
`define GAUSSIAN_BILINEAR_TAP_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define GBT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GBT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/gbt_pkg.sv
package gbt_pkg;

  localparam int MaxTaps   = 16;
  localparam int SampDepth = 2 * MaxTaps;
  localparam int SampAw    = $clog2(SampDepth);
  localparam int FwW       = $clog2(MaxTaps);
  localparam int ExpSteps  = 16;
  localparam int ExpAw     = $clog2(ExpSteps);

  localparam logic [26:0] MinWeightK = 27'd86127092;
  localparam logic [16:0] Log2eQ16   = 17'd94548;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgMaxTaps   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTexWidth  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTexHeight = 2'd2;

  // Shared divider.
  localparam int DvdW    = 51;
  localparam int DvsW    = 35;
  localparam int DivCntW = $clog2(DvdW + 1);

  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dividend;
    logic [DvsW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DvdW-1:0] quot;
  } div_rsp_t;

  // Square root unit used to build the exponent factor table.
  localparam int SqArgW  = 60;
  localparam int SqResW  = 30;
  localparam int SqCntW  = $clog2(SqResW + 1);

  typedef struct packed {
    logic              start;
    logic [SqArgW-1:0] arg;
  } sq_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [SqResW-1:0] root;
  } sq_rsp_t;

endpackage

FILE: hw/rtl/gbt_intf.sv
interface gbt_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] blur_sigma;
  logic [15:0] blur_intensity;
  modport source (output valid, blur_sigma, blur_intensity, input ready);
  modport sink   (input valid, blur_sigma, blur_intensity, output ready);
endinterface

interface gbt_tap_if;
  logic               valid;
  logic               ready;
  logic        [20:0] tap_weight;
  logic signed [21:0] horizontal_offset;
  logic signed [21:0] vertical_offset;
  logic               last_tap;
  logic               no_taps;
  modport source (output valid, tap_weight, horizontal_offset, vertical_offset, last_tap,
                  no_taps, input ready);
  modport sink   (input valid, tap_weight, horizontal_offset, vertical_offset, last_tap,
                  no_taps, output ready);
endinterface

interface gbt_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [gbt_pkg::CfgIdxW-1:0]  index;
  logic [gbt_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/gaussian_bilinear_tap_generator_unit.sv
// After reset the unit builds its 16-entry exponent factor table
// and accepts no item until that is done; configuration writes are taken throughout.
// The time per item grows with C window samples, B set fraction bits per sample, N kept
// samples and T taps, plus output stalls; the shared 51-step divider takes most of it.
// One item is worked at a time; results leave through an output register.
// Reset restores max_taps 8 and a 1024 x 1024 texture.
`include "gaussian_bilinear_tap_generator_unit_defines.svh"

module gaussian_bilinear_tap_generator_unit (
  input logic  clk_i,
  input logic  rst_ni,
  gbt_cfg_if.sink   cfg_i,
  gbt_req_if.sink   req_i,
  gbt_tap_if.source tap_o
);

  // Sequencer states.
  localparam logic [4:0] ST_INIT   = 5'd0;
  localparam logic [4:0] ST_INITW  = 5'd1;
  localparam logic [4:0] ST_IDLE   = 5'd2;
  localparam logic [4:0] ST_SETUP  = 5'd3;
  localparam logic [4:0] ST_UDIV   = 5'd4;
  localparam logic [4:0] ST_UDIVW  = 5'd5;
  localparam logic [4:0] ST_VCALC  = 5'd6;
  localparam logic [4:0] ST_EXP    = 5'd7;
  localparam logic [4:0] ST_EMUL   = 5'd8;
  localparam logic [4:0] ST_EUPD   = 5'd9;
  localparam logic [4:0] ST_EFIN   = 5'd10;
  localparam logic [4:0] ST_NRD    = 5'd11;
  localparam logic [4:0] ST_NMUL   = 5'd12;
  localparam logic [4:0] ST_NDIV   = 5'd13;
  localparam logic [4:0] ST_NDIVW  = 5'd14;
  localparam logic [4:0] ST_TRA    = 5'd15;
  localparam logic [4:0] ST_TRB    = 5'd16;
  localparam logic [4:0] ST_TSUM   = 5'd17;
  localparam logic [4:0] ST_TOFF   = 5'd18;
  localparam logic [4:0] ST_TOFFW  = 5'd19;
  localparam logic [4:0] ST_TPOS   = 5'd20;
  localparam logic [4:0] ST_THDIV  = 5'd21;
  localparam logic [4:0] ST_THW    = 5'd22;
  localparam logic [4:0] ST_TVDIV  = 5'd23;
  localparam logic [4:0] ST_TVW    = 5'd24;
  localparam logic [4:0] ST_TOUT   = 5'd25;
  localparam logic [4:0] ST_EMPTY  = 5'd26;

  localparam int SA = gbt_pkg::SampAw;
  localparam int FW = gbt_pkg::FwW;

  // Configuration registers.
  logic [4:0]  mt_q;
  logic [13:0] tw_q, th_q;

  // Control state.
  logic [4:0]      state_q, state_d;
  logic [4:0]      k_q, k_d;
  logic [SA-1:0]   x_q, x_d;
  logic [SA:0]     n_q, n_d;
  logic [FW-1:0]   i_q, i_d;
  logic            out_vld_q, out_vld_d;

  // Work registers.
  logic [15:0]        s_q, s_d, inten_q, inten_d;
  logic [FW-1:0]      fw_q, fw_d;
  logic [31:0]        ssq_q, ssq_d;
  logic [42:0]        thr_q, thr_d;
  logic [34:0]        total_q, total_d;
  logic [36:0]        vprod_q, vprod_d;
  logic [4:0]         nsh_q, nsh_d;
  logic [15:0]        fbits_q, fbits_d;
  logic [30:0]        e_q, e_d;
  logic [60:0]        prod_q, prod_d;
  logic [46:0]        nprod_q, nprod_d;
  logic [20:0]        a_q, a_d, b_q, b_d;
  logic [21:0]        sum_q, sum_d;
  logic [16:0]        off_q, off_d;
  logic [21:0]        mag_q, mag_d, hq_q, hq_d, vq_q, vq_d;
  logic               neg_q, neg_d;
  logic [29:0]        clast_q, clast_d;

  // Output register.
  logic [20:0] out_weight_q, out_weight_d;
  logic [21:0] out_h_q, out_h_d, out_v_q, out_v_d;
  logic        out_last_q, out_last_d, out_none_q, out_none_d;

  // Sample store (kept exponentials, later normalized weights) and factor table.
  logic [30:0]   smem [gbt_pkg::SampDepth];
  logic          smem_we;
  logic [SA-1:0] smem_wa, smem_ra;
  logic [30:0]   smem_wd, smem_rd_q;

  logic [29:0]              cmem [gbt_pkg::ExpSteps];
  logic                     cmem_we;
  logic [gbt_pkg::ExpAw-1:0] cmem_wa, cmem_ra;
  logic [29:0]              cmem_rd_q;

  gbt_pkg::div_req_t div_req;
  gbt_pkg::div_rsp_t div_rsp;
  gbt_pkg::sq_req_t  sq_req;
  gbt_pkg::sq_rsp_t  sq_rsp;

  gbt_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));
  gbt_isqrt u_isqrt (.clk_i, .rst_ni, .req_i(sq_req), .rsp_o(sq_rsp));

  // Helpers.
  logic [4:0]  mtc_w;
  logic [9:0]  t_w, tm1_w, lim_w;
  logic [SA-1:0] fwx_w, d_w;
  logic [9:0]  dd_w;
  logic [30:0] g_w;
  logic        keep_w;
  logic [SA:0] n_keep_w;
  logic [13:0] wdiv_w, hdiv_w;
  logic        hasb_w, last_w, load_w;
  logic signed [6:0]  diff_w;
  logic signed [23:0] p_w;
  logic [20:0] bsel_w;

  always_comb begin
    mtc_w = (mt_q == 5'd0) ? 5'd1 :
            (mt_q > 5'(gbt_pkg::MaxTaps)) ? 5'(gbt_pkg::MaxTaps) : mt_q;
    t_w   = 10'((18'(s_q) * 18'd3) >> 8);
    tm1_w = t_w - 10'd1;
    lim_w = 10'(mtc_w - 5'd1);
    fwx_w = SA'(fw_q);
    d_w   = (x_q >= fwx_w) ? (x_q - fwx_w) : (fwx_w - x_q);
    dd_w  = 10'(d_w) * 10'(d_w);
    g_w   = (nsh_q == 5'd31) ? 31'd0 : (e_q >> nsh_q);
    keep_w   = ({g_w, 16'd0} >= 47'(thr_q));
    n_keep_w = n_q + (SA+1)'(keep_w);
    wdiv_w = (tw_q == 14'd0) ? 14'd1 : tw_q;
    hdiv_w = (th_q == 14'd0) ? 14'd1 : th_q;
    hasb_w = ({1'b0, i_q, 1'b1} < n_q);
    bsel_w = hasb_w ? smem_rd_q[20:0] : 21'd0;
    last_w = (i_q == FW'((n_q - (SA+1)'(1)) >> 1));
    diff_w = $signed(7'({i_q, 1'b0})) - $signed(7'(fw_q));
    p_w    = $signed({diff_w[6:0], 16'd0}) + $signed(24'(off_q));
    load_w = !out_vld_q || tap_o.ready;
  end

  // Main sequencer.
  always_comb begin
    state_d = state_q;
    k_d = k_q; x_d = x_q; n_d = n_q; i_d = i_q;
    s_d = s_q; inten_d = inten_q; fw_d = fw_q; ssq_d = ssq_q; thr_d = thr_q;
    total_d = total_q; vprod_d = vprod_q; nsh_d = nsh_q; fbits_d = fbits_q;
    e_d = e_q; prod_d = prod_q; nprod_d = nprod_q; a_d = a_q; b_d = b_q;
    sum_d = sum_q; off_d = off_q; mag_d = mag_q; hq_d = hq_q; vq_d = vq_q;
    neg_d = neg_q; clast_d = clast_q;
    out_vld_d = out_vld_q && !tap_o.ready;
    out_weight_d = out_weight_q; out_h_d = out_h_q; out_v_d = out_v_q;
    out_last_d = out_last_q; out_none_d = out_none_q;
    smem_we = 1'b0; smem_wa = x_q; smem_wd = 31'd0; smem_ra = x_q;
    cmem_we = 1'b0; cmem_wa = k_q[gbt_pkg::ExpAw-1:0]; cmem_ra = k_q[gbt_pkg::ExpAw-1:0];
    div_req = '0;
    sq_req  = '0;

    case (state_q)
      // Factor table: c0 = isqrt(2^59), c(j+1) = isqrt(cj * 2^30).
      ST_INIT: begin
        sq_req.start = 1'b1;
        sq_req.arg   = (k_q == 5'd0) ? (gbt_pkg::SqArgW'(1) << 59) : {clast_q, 30'd0};
        state_d      = ST_INITW;
      end
      ST_INITW: begin
        if (sq_rsp.done) begin
          cmem_we = 1'b1;
          clast_d = sq_rsp.root;
          if (k_q == 5'(gbt_pkg::ExpSteps - 1)) begin
            k_d     = 5'd0;
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + 5'd1;
            state_d = ST_INIT;
          end
        end
      end
      ST_IDLE: begin
        if (req_i.valid) begin
          s_d     = (req_i.blur_sigma == 16'd0) ? 16'd1 : req_i.blur_sigma;
          inten_d = req_i.blur_intensity;
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        fw_d    = (t_w == 10'd0) ? '0 : FW'((tm1_w > lim_w) ? lim_w : tm1_w);
        ssq_d   = s_q * s_q;
        thr_d   = 43'(s_q) * 43'(gbt_pkg::MinWeightK);
        x_d     = '0;
        n_d     = '0;
        total_d = '0;
        state_d = ST_UDIV;
      end
      // u = d^2 * 2^31 / s^2
      ST_UDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = gbt_pkg::DvdW'({dd_w, 31'd0});
        div_req.divisor  = gbt_pkg::DvsW'(ssq_q);
        state_d          = ST_UDIVW;
      end
      ST_UDIVW: begin
        if (div_rsp.done) begin
          // The window bound keeps u below 2^20.
          vprod_d = 37'(div_rsp.quot[19:0]) * 37'(gbt_pkg::Log2eQ16) + 37'd32768;
          state_d = ST_VCALC;
        end
      end
      ST_VCALC: begin
        nsh_d   = vprod_q[36:32];
        fbits_d = vprod_q[31:16];
        e_d     = 31'd1 << 30;
        k_d     = 5'd0;
        state_d = ST_EXP;
      end
      // 2^-f: one factor multiply for each set fraction bit, top bit first.
      ST_EXP: begin
        if (k_q == 5'(gbt_pkg::ExpSteps)) begin
          state_d = ST_EFIN;
        end else if (fbits_q[15]) begin
          state_d = ST_EMUL;
        end else begin
          fbits_d = fbits_q << 1;
          k_d     = k_q + 5'd1;
        end
      end
      ST_EMUL: begin
        prod_d  = 61'(e_q) * 61'(cmem_rd_q);
        state_d = ST_EUPD;
      end
      ST_EUPD: begin
        e_d     = 31'((prod_q + (61'd1 << 29)) >> 30);
        fbits_d = fbits_q << 1;
        k_d     = k_q + 5'd1;
        state_d = ST_EXP;
      end
      ST_EFIN: begin
        if (keep_w) begin
          smem_we = 1'b1;
          smem_wa = n_q[SA-1:0];
          smem_wd = g_w;
          total_d = total_q + 35'(g_w);
        end
        n_d = n_keep_w;
        if (x_q == SA'({fw_q, 1'b0})) begin
          x_d     = '0;
          state_d = (n_keep_w == '0) ? ST_EMPTY : ST_NRD;
        end else begin
          x_d     = x_q + 1'b1;
          state_d = ST_UDIV;
        end
      end
      // w = (e * I * 16 + T/2) / T, written back in place.
      ST_NRD: begin
        state_d = ST_NMUL;
      end
      ST_NMUL: begin
        nprod_d = 47'(smem_rd_q) * 47'(inten_q);
        state_d = ST_NDIV;
      end
      ST_NDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = {nprod_q, 4'd0} + gbt_pkg::DvdW'(total_q >> 1);
        div_req.divisor  = total_q;
        state_d          = ST_NDIVW;
      end
      ST_NDIVW: begin
        if (div_rsp.done) begin
          smem_we = 1'b1;
          smem_wd = 31'(div_rsp.quot[20:0]);
          if ((SA+1)'(x_q) == n_q - (SA+1)'(1)) begin
            i_d     = '0;
            state_d = ST_TRA;
          end else begin
            x_d     = x_q + 1'b1;
            state_d = ST_NRD;
          end
        end
      end
      ST_TRA: begin
        smem_ra = {i_q, 1'b0};
        state_d = ST_TRB;
      end
      ST_TRB: begin
        a_d     = smem_rd_q[20:0];
        smem_ra = {i_q, 1'b1};
        state_d = ST_TSUM;
      end
      ST_TSUM: begin
        b_d     = bsel_w;
        sum_d   = 22'(a_q) + 22'(bsel_w);
        state_d = ST_TOFF;
      end
      ST_TOFF: begin
        if (sum_q == 22'd0) begin
          off_d   = '0;
          state_d = ST_TPOS;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = gbt_pkg::DvdW'({b_q, 16'd0}) + gbt_pkg::DvdW'(sum_q >> 1);
          div_req.divisor  = gbt_pkg::DvsW'(sum_q);
          state_d          = ST_TOFFW;
        end
      end
      ST_TOFFW: begin
        if (div_rsp.done) begin
          off_d   = div_rsp.quot[16:0];
          state_d = ST_TPOS;
        end
      end
      ST_TPOS: begin
        neg_d   = p_w[23];
        mag_d   = p_w[23] ? 22'(-p_w) : 22'(p_w);
        state_d = ST_THDIV;
      end
      ST_THDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = gbt_pkg::DvdW'(mag_q) + gbt_pkg::DvdW'(wdiv_w >> 1);
        div_req.divisor  = gbt_pkg::DvsW'(wdiv_w);
        state_d          = ST_THW;
      end
      ST_THW: begin
        if (div_rsp.done) begin
          hq_d    = div_rsp.quot[21:0];
          state_d = ST_TVDIV;
        end
      end
      ST_TVDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = gbt_pkg::DvdW'(mag_q) + gbt_pkg::DvdW'(hdiv_w >> 1);
        div_req.divisor  = gbt_pkg::DvsW'(hdiv_w);
        state_d          = ST_TVW;
      end
      ST_TVW: begin
        if (div_rsp.done) begin
          vq_d    = div_rsp.quot[21:0];
          state_d = ST_TOUT;
        end
      end
      ST_TOUT: begin
        if (load_w) begin
          out_vld_d    = 1'b1;
          out_weight_d = sum_q[20:0];
          out_h_d      = neg_q ? (22'd0 - hq_q) : hq_q;
          out_v_d      = neg_q ? (22'd0 - vq_q) : vq_q;
          out_last_d   = last_w;
          out_none_d   = 1'b0;
          if (last_w) begin
            state_d = ST_IDLE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = ST_TRA;
          end
        end
      end
      ST_EMPTY: begin
        if (load_w) begin
          out_vld_d    = 1'b1;
          out_weight_d = '0;
          out_h_d      = '0;
          out_v_d      = '0;
          out_last_d   = 1'b0;
          out_none_d   = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Normalization reads the entry it is about to rewrite.
    if (state_q == ST_NRD) begin
      smem_ra = x_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      k_q       <= '0;
      x_q       <= '0;
      n_q       <= '0;
      i_q       <= '0;
      out_vld_q <= 1'b0;
      mt_q      <= 5'd8;
      tw_q      <= 14'd1024;
      th_q      <= 14'd1024;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      x_q       <= x_d;
      n_q       <= n_d;
      i_q       <= i_d;
      out_vld_q <= out_vld_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          gbt_pkg::CfgMaxTaps:   mt_q <= cfg_i.data[4:0];
          gbt_pkg::CfgTexWidth:  tw_q <= cfg_i.data[13:0];
          gbt_pkg::CfgTexHeight: th_q <= cfg_i.data[13:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    s_q <= s_d; inten_q <= inten_d; fw_q <= fw_d; ssq_q <= ssq_d; thr_q <= thr_d;
    total_q <= total_d; vprod_q <= vprod_d; nsh_q <= nsh_d; fbits_q <= fbits_d;
    e_q <= e_d; prod_q <= prod_d; nprod_q <= nprod_d; a_q <= a_d; b_q <= b_d;
    sum_q <= sum_d; off_q <= off_d; mag_q <= mag_d; hq_q <= hq_d; vq_q <= vq_d;
    neg_q <= neg_d; clast_q <= clast_d;
    out_weight_q <= out_weight_d; out_h_q <= out_h_d; out_v_q <= out_v_d;
    out_last_q <= out_last_d; out_none_q <= out_none_d;
  end

  // Memories with registered reads.
  always_ff @(posedge clk_i) begin
    if (smem_we) begin
      smem[smem_wa] <= smem_wd;
    end
    smem_rd_q <= smem[smem_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmem_we) begin
      cmem[cmem_wa] <= sq_rsp.root;
    end
    cmem_rd_q <= cmem[cmem_ra];
  end

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == ST_IDLE);

  assign tap_o.valid             = out_vld_q;
  assign tap_o.tap_weight        = out_weight_q;
  assign tap_o.horizontal_offset = out_h_q;
  assign tap_o.vertical_offset   = out_v_q;
  assign tap_o.last_tap          = out_last_q;
  assign tap_o.no_taps           = out_none_q;

  `GBT_ASSERT_NXT(a_req_starts_setup, req_i.valid && req_i.ready, state_q == ST_SETUP, "item not set up")
  `GBT_ASSERT_IMP(a_div_start_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")
  `GBT_ASSERT_IMP(a_empty_clean, out_vld_q && out_none_q, out_weight_q == 21'd0 && !out_last_q, "empty result carries data")
  `GBT_ASSERT_IMP(a_norm_nonzero_total, state_q == ST_NDIV, total_q != 35'd0, "normalizing by zero")

endmodule

FILE: hw/rtl/gbt_div.sv
module gbt_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gbt_pkg::div_req_t req_i,
  output gbt_pkg::div_rsp_t rsp_o
);

  logic                        busy_q, done_q;
  logic [gbt_pkg::DivCntW-1:0] cnt_q;
  logic [gbt_pkg::DvdW-1:0]    dvd_q;
  logic [gbt_pkg::DvsW-1:0]    dvs_q, rem_q;
  logic [gbt_pkg::DvsW:0]      rem_sh, rem_sub;
  logic                        qbit;

  // Restoring division, one quotient bit a cycle; quotient bits replace
  // the dividend bits as they are shifted out.
  always_comb begin
    rem_sh  = {rem_q, dvd_q[gbt_pkg::DvdW-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    qbit    = (rem_sh >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == gbt_pkg::DivCntW'(gbt_pkg::DvdW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[gbt_pkg::DvdW-2:0], qbit};
      rem_q <= qbit ? rem_sub[gbt_pkg::DvsW-1:0] : rem_sh[gbt_pkg::DvsW-1:0];
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;

endmodule

FILE: hw/rtl/gbt_isqrt.sv
module gbt_isqrt (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gbt_pkg::sq_req_t req_i,
  output gbt_pkg::sq_rsp_t rsp_o
);

  logic                       busy_q, done_q;
  logic [gbt_pkg::SqCntW-1:0] cnt_q;
  logic [gbt_pkg::SqArgW-1:0] x_q, r_q, bit_q, trial;
  logic                       take;

  always_comb begin
    trial = r_q + bit_q;
    take  = (x_q >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == gbt_pkg::SqCntW'(gbt_pkg::SqResW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Digit-by-digit root, two argument bits per cycle.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q   <= req_i.arg;
      r_q   <= '0;
      bit_q <= gbt_pkg::SqArgW'(1) << (gbt_pkg::SqArgW - 2);
    end else if (busy_q) begin
      if (take) begin
        x_q <= x_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.root = r_q[gbt_pkg::SqResW-1:0];

endmodule

FILE: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 60000;
  localparam logic [gbt_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;

  // One tap as the block should emit it.
  typedef struct packed {
    logic [20:0] weight;
    logic [21:0] h_off;
    logic [21:0] v_off;
    logic        last;
    logic        none;
  } tap_t;

  // Tap predictor and store of taps still owed by the block.
  class tap_scoreboard;
    tap_t            owed[$];
    longint unsigned root_step[1:16];
    longint unsigned tap_limit, tex_w, tex_h;
    int              mismatches;

    function new();
      root_step[1] = isqrt(64'd1 << 59);
      for (int j = 2; j <= 16; j++) root_step[j] = isqrt(root_step[j-1] << 30);
      tap_limit = 8;
      tex_w     = 1024;
      tex_h     = 1024;
    endfunction

    static function longint unsigned isqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void write_reg(logic [gbt_pkg::CfgIdxW-1:0] idx,
                            logic [gbt_pkg::CfgDataW-1:0] data);
      case (idx)
        gbt_pkg::CfgMaxTaps:   tap_limit = data[4:0];
        gbt_pkg::CfgTexWidth:  tex_w     = data[13:0];
        gbt_pkg::CfgTexHeight: tex_h     = data[13:0];
        default: ;
      endcase
    endfunction

    // Gaussian sample in Q1.30 via 2^-v built from the square root ladder.
    function longint unsigned gauss(longint unsigned d, longint unsigned s);
      longint unsigned u, v, sh, f, e;
      u  = ((d * d) << 31) / (s * s);
      v  = (u * 94548 + 32768) >> 16;
      sh = v >> 16;
      f  = v & 16'hFFFF;
      if (sh >= 31) return 0;
      e = 64'd1 << 30;
      for (int j = 1; j <= 16; j++)
        if ((f >> (16 - j)) & 1) e = (e * root_step[j] + (64'd1 << 29)) >> 30;
      return e >> sh;
    endfunction

    function logic [21:0] scale(longint p, longint unsigned dv);
      longint unsigned mag, q;
      mag = (p < 0) ? longint'(-p) : longint'(p);
      q   = (mag + dv / 2) / dv;
      return (p < 0) ? 22'(-q) : 22'(q);
    endfunction

    function void note_request(logic [15:0] sigma, logic [15:0] inten);
      longint unsigned s, mt, wd, hd, g, total, a, b, sum, off;
      longint unsigned e[32], w[32];
      longint          fw, p;
      int              kept, taps;
      tap_t            t;
      s     = (sigma == 0) ? 1 : sigma;
      mt    = (tap_limit < 1) ? 1 :
              (tap_limit > gbt_pkg::MaxTaps ? gbt_pkg::MaxTaps : tap_limit);
      wd    = tex_w ? tex_w : 1;
      hd    = tex_h ? tex_h : 1;
      total = 0;
      kept  = 0;
      fw    = longint'((3 * s) >> 8) - 1;
      if (fw < 0) fw = 0;
      if (fw > longint'(mt) - 1) fw = longint'(mt) - 1;
      for (longint x = 0; x <= 2 * fw; x++) begin
        g = gauss((x < fw) ? fw - x : x - fw, s);
        if (g * 65536 >= s * 86127092) begin
          e[kept++] = g;
          total += g;
        end
      end
      if (kept == 0) begin
        t      = '0;
        t.none = 1'b1;
        owed.push_back(t);
        return;
      end
      for (int x = 0; x < kept; x++) w[x] = (e[x] * inten * 16 + total / 2) / total;
      taps = (kept + 1) / 2;
      for (int i = 0; i < taps; i++) begin
        a   = w[2*i];
        b   = (2 * i + 1 < kept) ? w[2*i+1] : 0;
        sum = a + b;
        off = sum ? (b * 65536 + sum / 2) / sum : 0;
        p   = (longint'(2 * i) - fw) * 65536 + longint'(off);
        t.weight = sum[20:0];
        t.h_off  = scale(p, wd);
        t.v_off  = scale(p, hd);
        t.last   = (i == taps - 1);
        t.none   = 1'b0;
        owed.push_back(t);
      end
    endfunction

    function void check_tap(tap_t got);
      tap_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected tap %p", got);
        return;
      end
      want = owed.pop_front();
      if (got.weight !== want.weight || got.h_off !== want.h_off ||
          got.v_off !== want.v_off || got.last !== want.last || got.none !== want.none) begin
        mismatches++;
        if (mismatches <= 10) $display("tap mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  gbt_cfg_if cfg_if ();
  gbt_req_if req_if ();
  gbt_tap_if tap_if ();

  gaussian_bilinear_tap_generator_unit i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if.sink),
    .req_i (req_if.sink),
    .tap_o (tap_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  tap_scoreboard blur_taps = new();

  // When steady is set neither side inserts gaps; hold_taps is the long back-pressure window.
  logic steady    = 1'b0;
  logic hold_taps = 1'b0;
  int   stall_left = 0;
  int   idle_cycles = 0;

  // Tap receiver: checks every accepted tap and throttles ready, sometimes for long stretches.
  always @(posedge clk_i) begin
    if (tap_if.valid && tap_if.ready) begin
      blur_taps.check_tap({tap_if.tap_weight, tap_if.horizontal_offset,
                           tap_if.vertical_offset, tap_if.last_tap, tap_if.no_taps});
    end
    if (!rst_ni || hold_taps) begin
      tap_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      tap_if.ready <= 1'b0;
    end else if (steady) begin
      tap_if.ready <= 1'b1;
    end else if ($urandom_range(0, 99) == 0) begin
      stall_left   <= $urandom_range(20, 150);
      tap_if.ready <= 1'b0;
    end else begin
      tap_if.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Watchdog: counts cycles in which no channel moves an item.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (tap_if.valid && tap_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IdleLimit) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    if (steady) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(30, 200);
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
  endfunction

  task automatic send_request(logic [15:0] sigma, logic [15:0] inten);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.blur_sigma     <= sigma;
    req_if.blur_intensity <= inten;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    blur_taps.note_request(sigma, inten);
  endtask

  // Drops valid and waits until every owed tap has come back.
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (blur_taps.owed.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [gbt_pkg::CfgIdxW-1:0] idx,
                           logic [gbt_pkg::CfgDataW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    blur_taps.write_reg(idx, data);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random sigma: mostly 1 to 1600, sometimes 0 to 200 or anything the field allows.
  function automatic logic [15:0] rand_sigma();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'($urandom_range(0, 200));
      default: return 16'($urandom_range(1, 1600));
    endcase
  endfunction

  initial begin
    logic [15:0] phase_cfg[7][3] = '{
      '{16'd8, 16'd1024, 16'd1024},
      '{16'd16, 16'd8192, 16'd8192},
      '{16'd1, 16'd1, 16'd1},
      '{16'd0, 16'd0, 16'd0},
      '{16'd31, 16'd16383, 16'd16383},
      '{16'd5, 16'd640, 16'd480},
      '{16'd12, 16'd3, 16'd7}
    };
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data  = '0;
    req_if.valid = 1'b0;
    req_if.blur_sigma     = '0;
    req_if.blur_intensity = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items at the reset settings: zero sigma, field extremes, window edges.
    send_request(16'd0, 16'd4096);
    send_request(16'd1, 16'd0);
    send_request(16'd65535, 16'd65535);
    send_request(16'd65535, 16'd0);
    send_request(16'd170, 16'd4096);
    send_request(16'd171, 16'd4096);
    send_request(16'd256, 16'hFFFF);
    send_request(16'd512, 16'd1);
    send_request(16'd768, 16'h8000);
    send_request(16'd2048, 16'd4096);
    send_request(16'h5555, 16'hAAAA);
    send_request(16'hAAAA, 16'h5555);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      write_reg(gbt_pkg::CfgMaxTaps, phase_cfg[ph][0]);
      write_reg(gbt_pkg::CfgTexWidth, phase_cfg[ph][1]);
      write_reg(gbt_pkg::CfgTexHeight, phase_cfg[ph][2]);
      // An unused register index must change nothing.
      write_reg(CfgUnused, 16'($urandom_range(0, 65535)));
      steady = (ph == 3);
      if (ph == 1) begin
        // Long back-pressure while requests keep coming, so the block fills and stalls.
        fork
          begin
            hold_taps <= 1'b1;
            repeat (3000) @(posedge clk_i);
            hold_taps <= 1'b0;
          end
        join_none
      end
      for (int k = 0; k < 44; k++) send_request(rand_sigma(), 16'($urandom_range(0, 65535)));
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (blur_taps.mismatches == 0 && blur_taps.owed.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/gbt_pkg.sv
hw/rtl/gbt_intf.sv
hw/rtl/gbt_div.sv
hw/rtl/gbt_isqrt.sv
hw/rtl/gaussian_bilinear_tap_generator_unit.sv
dv/tb.sv
